// File: rtl/oaht_pkg.sv
// Shared types, codes and helper functions of the open-addressing hash table.
`default_nettype none
package oaht_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int KEY_W     = 31;
  localparam int SIZE_W    = 7;
  localparam int CFG_W     = 7;
  localparam int COLL_W    = 32;
  localparam int DIV_STEPS = KEY_W;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_DEAD  = 2'd2;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] MODE_LIN  = 2'd0;
  localparam logic [1:0] MODE_QUAD = 2'd1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [5:0]        slot_index;
    logic [COLL_W-1:0] collision_total;
    logic              table_full;
    logic              table_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_SETUP, S_RD, S_CHK, S_CLR, S_CNT0, S_CNT, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic setup;
    logic probe_rd;
    logic probe_chk;
    logic clr_step;
    logic cnt_init;
    logic cnt_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic probe_stop;
    logic clr_done;
    logic cnt_done;
    logic out_free;
  } sts_t;

  // (a + b) mod n for a, b < n
  function automatic logic [SIZE_W-1:0] add_mod(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b,
                                                input logic [SIZE_W-1:0] n);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[SIZE_W-1:0];
  endfunction

  // v mod n for v below 8, n at least 1
  function automatic logic [SIZE_W-1:0] small_mod(input logic [2:0] v,
                                                  input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] r;
    r = {4'b0, v};
    for (int k = 0; k < 7; k++) begin
      if (r >= n) r = r - n;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/oaht_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module oaht_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/oaht_ctrl.sv
// Request sequencer: state machine issuing datapath commands.
`default_nettype none
module oaht_ctrl import oaht_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_action,
  output logic            in_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_CLEAR) ? S_CLR : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        cmd.probe_chk = 1'b1;
        state_nxt     = sts.probe_stop ? S_CNT0 : S_RD;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_CNT0;
      end
      S_CNT0: begin
        cmd.cnt_init = 1'b1;
        state_nxt    = S_CNT;
      end
      S_CNT: begin
        cmd.cnt_step = 1'b1;
        if (sts.cnt_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/oaht_dp.sv
// Datapath: config registers, key/tag stores, remainder unit, probe stepper, counters.
`default_nettype none
module oaht_dp import oaht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_item_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  wire cmd_t             cmd,
  output sts_t                  sts
);
  localparam int IW   = $clog2(SLOTS);
  localparam int NMAX = (SLOTS < 127) ? SLOTS : 127;

  logic [1:0]        mode_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] n_cur, n_r;
  logic [1:0]        act_r;
  logic [KEY_W-1:0]  key_r, sh_r;
  logic [4:0]        div_cnt_r;
  logic [SIZE_W-1:0] rem_n_r;
  logic [2:0]        rem7_r;
  logic [SIZE_W-1:0] pos_r, dlt_r, c6_r, i_r;
  logic [SIZE_W-1:0] j_r, live_r, used_r;
  logic              pv_r;
  logic [IW-1:0]     clr_r;
  logic [COLL_W-1:0] coll_r;
  logic              fail_r;
  logic [SIZE_W-1:0] where_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [1:0]        tag_rd;
  logic [KEY_W-1:0]  key_rd;
  logic              tag_we, key_we;
  logic [1:0]        tag_wd;
  logic [IW-1:0]     waddr, raddr;
  logic              hit, stop, is_ins, last;
  logic [SIZE_W:0]   tn;
  logic [3:0]        t7;
  logic [2:0]        hstep;

  // effective size in use
  always_comb begin
    if (size_r == '0)                   n_cur = SIZE_W'(1);
    else if (size_r > SIZE_W'(NMAX))    n_cur = SIZE_W'(NMAX);
    else                                n_cur = size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LIN;
      size_r <= SIZE_W'(13);
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) mode_r <= cfg_data[1:0];
      else                       size_r <= cfg_data;
    end
  end

  // probe decision
  assign is_ins = (act_r == ACT_INSERT);
  assign last   = (i_r == n_r - SIZE_W'(1));
  always_comb begin
    if (is_ins) hit = (tag_rd != TAG_LIVE);
    else        hit = (tag_rd == TAG_LIVE) && (key_rd == key_r);
    stop = hit || last || (!is_ins && tag_rd == TAG_EMPTY);
  end

  // store writes
  always_comb begin
    tag_we = 1'b0;
    key_we = 1'b0;
    tag_wd = TAG_EMPTY;
    waddr  = IW'(pos_r);
    if (cmd.clr_step) begin
      tag_we = 1'b1;
      waddr  = clr_r;
    end else if (cmd.probe_chk && hit) begin
      if (is_ins) begin
        tag_we = 1'b1;
        key_we = 1'b1;
        tag_wd = TAG_LIVE;
      end else if (act_r == ACT_DELETE) begin
        tag_we = 1'b1;
        tag_wd = TAG_DEAD;
      end
    end
  end
  assign raddr = cmd.cnt_step ? IW'(j_r) : IW'(pos_r);

  oaht_ram #(.W(2), .D(SLOTS)) u_tags (
    .clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wd), .raddr(raddr), .rdata(tag_rd)
  );
  oaht_ram #(.W(KEY_W), .D(SLOTS)) u_keys (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_r), .raddr(raddr), .rdata(key_rd)
  );

  // bit-serial remainders: key mod n and key mod 7
  always_comb begin
    tn = {rem_n_r, sh_r[KEY_W-1]};
    if (tn >= {1'b0, n_r}) tn = tn - {1'b0, n_r};
    t7 = {rem7_r, sh_r[KEY_W-1]};
    if (t7 >= 4'd7) t7 = t7 - 4'd7;
    hstep = 3'(4'd7 - {1'b0, rem7_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_data.action;
      key_r     <= in_data.key;
      sh_r      <= in_data.key;
      n_r       <= n_cur;
      div_cnt_r <= '0;
      rem_n_r   <= '0;
      rem7_r    <= '0;
      where_r   <= '0;
    end
    if (cmd.div_step) begin
      sh_r      <= {sh_r[KEY_W-2:0], 1'b0};
      rem_n_r   <= tn[SIZE_W-1:0];
      rem7_r    <= t7[2:0];
      div_cnt_r <= div_cnt_r + 5'd1;
    end
    if (cmd.setup) begin
      pos_r <= rem_n_r;
      i_r   <= '0;
      c6_r  <= small_mod(3'd6, n_r);
      case (mode_r)
        MODE_LIN:  dlt_r <= small_mod(3'd1, n_r);
        MODE_QUAD: dlt_r <= small_mod(3'd4, n_r);
        default:   dlt_r <= small_mod(hstep, n_r);
      endcase
    end
    if (cmd.probe_chk) begin
      if (hit) where_r <= pos_r;
      else if (!stop) begin
        i_r   <= i_r + SIZE_W'(1);
        pos_r <= add_mod(pos_r, dlt_r, n_r);
        if (mode_r == MODE_QUAD) dlt_r <= add_mod(dlt_r, c6_r, n_r);
      end
    end
    if (cmd.cnt_init) begin
      j_r    <= '0;
      live_r <= '0;
      used_r <= '0;
    end
    if (cmd.cnt_step) begin
      if (j_r < n_r) j_r <= j_r + SIZE_W'(1);
      if (pv_r) begin
        if (tag_rd == TAG_LIVE)  live_r <= live_r + SIZE_W'(1);
        if (tag_rd != TAG_EMPTY) used_r <= used_r + SIZE_W'(1);
      end
    end
    if (cmd.finish) begin
      out_r.status          <= fail_r;
      out_r.slot_index      <= where_r[5:0];
      out_r.collision_total <= coll_r;
      out_r.table_full      <= (live_r == n_r);
      out_r.table_empty     <= (used_r == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      coll_r      <= '0;
      fail_r      <= 1'b1;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= sts.clr_done ? '0 : clr_r + IW'(1);
      if (cmd.load) begin
        fail_r <= (in_data.action != ACT_CLEAR);
        if (in_data.action == ACT_CLEAR) coll_r <= '0;
      end
      if (cmd.probe_chk) begin
        if (hit) fail_r <= 1'b0;
        else if (is_ins && coll_r != '1) coll_r <= coll_r + COLL_W'(1);
      end
      if (cmd.cnt_init)      pv_r <= 1'b0;
      else if (cmd.cnt_step) pv_r <= (j_r < n_r);
      if (cmd.finish)         out_valid_r <= 1'b1;
      else if (!out_stall)    out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.div_done   = (div_cnt_r == 5'(DIV_STEPS - 1));
    sts.probe_stop = stop;
    sts.clr_done   = (clr_r == IW'(SLOTS - 1));
    sts.cnt_done   = (j_r == n_r) && !pv_r;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// File: rtl/open_address_hash_table_top.sv
// Top level of the open-addressing hash table: sequencer plus datapath.
//
// Input channel (in_valid/in_stall/in_data): one request item per handshake,
// action insert, search, delete or clear, with a 31-bit key.
// Result channel (out_valid/out_stall/out_data): exactly one result item per
// request: status, slot index, collision total, full and empty flags.
// Configuration (cfg_we/cfg_index/cfg_data): index 0 probe mode, index 1 size.
// Write only while no request is in flight.
//
// Steps per item: the key remainder (bit-serial unit), one setup step, then a
// tag/key read and a decide step per probe slot, then a flag recount over
// every slot of the configured size, then a load of the output register. A
// clear replaces remainder and probing with a sweep over all SLOTS tag
// entries. One item is in work at a time.
// Reset: synchronous, active low; afterwards a sweep over all SLOTS entries
// empties the tag store, with in_stall high, before the first item is taken.
// A stalled result holds in the output register; the next request may be
// taken meanwhile, and its result waits until the register frees up.
`default_nettype none
module open_address_hash_table_top import oaht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  oaht_dp #(.SLOTS(SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );
endmodule
`default_nettype wire

// File: rtl/oaht_chk.sv
// Port-level checker for the hash table top, with its bind.
`default_nettype none
module oaht_chk import oaht_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_fail_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.slot_index == 6'd0)
    else $error("failed request reports a slot");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.table_full && out_data.table_empty))
    else $error("table both full and empty");
endmodule

bind open_address_hash_table_top oaht_chk u_oaht_chk (.*);
`default_nettype wire
